// ----- sv/awvd_pkg.sv -----
// ----------------------------------------------------------------------------
// awvd_pkg
// Shared widths, constants and payload types of the alpha-weighted voxel
// downsampler.
// ----------------------------------------------------------------------------
package awvd_pkg;

  localparam int unsigned CORNERS        = 8;
  localparam int unsigned CHANNELS       = 3;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned VOXEL_W        = 32;
  localparam int unsigned ALPHA_BYTE     = 3;
  localparam int unsigned PROD_W         = 2 * BYTE_W;
  localparam int unsigned ASUM_W         = 11;
  localparam int unsigned NUM_W          = 20;
  localparam int unsigned QUOT_W         = 8;
  localparam int unsigned QBIT_W         = $clog2(QUOT_W);
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES     = QUOT_W / BITS_PER_STAGE;
  localparam int unsigned ROUND_ALPHA    = 4;
  localparam int unsigned ALPHA_SHIFT    = 3;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QUEUE_AW       = $clog2(QUEUE_DEPTH);
  localparam int unsigned FRONT_STAGES   = 2;
  localparam int unsigned CAPACITY       = FRONT_STAGES + QUEUE_DEPTH + DIV_STAGES;
  localparam int unsigned CNT_W          = $clog2(CAPACITY + 1);
  localparam int unsigned IN_W           = CORNERS * VOXEL_W;
  localparam int unsigned OUT_W          = 4 * BYTE_W;

  typedef struct packed {
    logic [CHANNELS-1:0][NUM_W-1:0] num;
    logic [ASUM_W-1:0]              den;
    logic                           zero;
    logic [BYTE_W-1:0]              alpha;
  } acc_t;

  typedef struct packed {
    logic [CHANNELS-1:0][NUM_W-1:0]  rem;
    logic [CHANNELS-1:0][QUOT_W-1:0] quot;
    logic [ASUM_W-1:0]               den;
    logic                            zero;
    logic [BYTE_W-1:0]               alpha;
  } quot_t;

endpackage

// ----- sv/awvd_front.sv -----
// ----------------------------------------------------------------------------
// awvd_front
// Input stage: unpacks the eight corners, forms colour-times-alpha products and
// the alpha sum, then the rounded numerators, zero flag and output alpha.
// ----------------------------------------------------------------------------
module awvd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  input  logic [awvd_pkg::IN_W-1:0]   s_tdata_i,
  output logic                        acc_valid_o,
  input  logic                        acc_ready_i,
  output awvd_pkg::acc_t              acc_o
);

  logic [awvd_pkg::CORNERS-1:0][awvd_pkg::CHANNELS-1:0][awvd_pkg::PROD_W-1:0] prod_d, prod_q;
  logic [awvd_pkg::ASUM_W-1:0] asum_d, asum_q;
  logic [awvd_pkg::ASUM_W-1:0] alpha_rnd;
  logic [awvd_pkg::CHANNELS-1:0][awvd_pkg::NUM_W-1:0] wsum;
  logic [awvd_pkg::VOXEL_W-1:0] voxel;
  logic [awvd_pkg::BYTE_W-1:0]  alpha;
  awvd_pkg::acc_t acc_d, acc_q;
  logic p1_valid_q, p2_valid_q;
  logic p1_en, p2_en;

  assign p2_en      = !p2_valid_q || acc_ready_i;
  assign p1_en      = !p1_valid_q || p2_en;
  assign s_tready_o = p1_en;

  always_comb begin
    prod_d = '0;
    asum_d = '0;
    voxel  = '0;
    alpha  = '0;
    for (int c = 0; c < awvd_pkg::CORNERS; c++) begin
      voxel  = s_tdata_i[c*awvd_pkg::VOXEL_W +: awvd_pkg::VOXEL_W];
      alpha  = voxel[awvd_pkg::ALPHA_BYTE*awvd_pkg::BYTE_W +: awvd_pkg::BYTE_W];
      asum_d = asum_d + awvd_pkg::ASUM_W'(alpha);
      for (int j = 0; j < awvd_pkg::CHANNELS; j++) begin
        prod_d[c][j] = awvd_pkg::PROD_W'(voxel[j*awvd_pkg::BYTE_W +: awvd_pkg::BYTE_W])
                     * awvd_pkg::PROD_W'(alpha);
      end
    end
  end

  always_comb begin
    wsum = '0;
    for (int j = 0; j < awvd_pkg::CHANNELS; j++) begin
      for (int c = 0; c < awvd_pkg::CORNERS; c++) begin
        wsum[j] = wsum[j] + awvd_pkg::NUM_W'(prod_q[c][j]);
      end
    end
    alpha_rnd = asum_q + awvd_pkg::ASUM_W'(awvd_pkg::ROUND_ALPHA);
    for (int j = 0; j < awvd_pkg::CHANNELS; j++) begin
      acc_d.num[j] = wsum[j] + awvd_pkg::NUM_W'(asum_q >> 1);
    end
    acc_d.den   = asum_q;
    acc_d.zero  = (asum_q == '0);
    acc_d.alpha = alpha_rnd[awvd_pkg::ALPHA_SHIFT +: awvd_pkg::BYTE_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
    end else begin
      if (p1_en) p1_valid_q <= s_tvalid_i;
      if (p2_en) p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_en && s_tvalid_i) begin
      prod_q <= prod_d;
      asum_q <= asum_d;
    end
    if (p2_en && p1_valid_q) acc_q <= acc_d;
  end

  assign acc_valid_o = p2_valid_q;
  assign acc_o       = acc_q;

endmodule

// ----- sv/awvd_queue.sv -----
// ----------------------------------------------------------------------------
// awvd_queue
// Short FIFO between the front and the divider, so each side stalls alone.
// ----------------------------------------------------------------------------
module awvd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  awvd_pkg::acc_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output awvd_pkg::acc_t pop_data_o
);

  awvd_pkg::acc_t mem_q [awvd_pkg::QUEUE_DEPTH];
  logic [awvd_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [awvd_pkg::QUEUE_AW:0]   cnt_q, cnt_d;
  logic push, pop;

  assign push_ready_o = (cnt_q != (awvd_pkg::QUEUE_AW+1)'(awvd_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ----- sv/awvd_back.sv -----
// ----------------------------------------------------------------------------
// awvd_back
// Pipelined restoring divider, two quotient bits per stage for all three
// colours; the last stage doubles as the output register.
// ----------------------------------------------------------------------------
module awvd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        acc_valid_i,
  output logic                        acc_ready_o,
  input  awvd_pkg::acc_t              acc_i,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [awvd_pkg::OUT_W-1:0]  m_tdata_o
);

  localparam int unsigned LAST = awvd_pkg::DIV_STAGES - 1;

  awvd_pkg::quot_t st_q  [awvd_pkg::DIV_STAGES];
  awvd_pkg::quot_t st_in [awvd_pkg::DIV_STAGES];
  awvd_pkg::quot_t st_d  [awvd_pkg::DIV_STAGES];
  logic [awvd_pkg::DIV_STAGES-1:0] vld_q, vld_in, rdy;

  function automatic awvd_pkg::quot_t div_step(awvd_pkg::quot_t x, int unsigned k);
    awvd_pkg::quot_t         y;
    logic [awvd_pkg::NUM_W-1:0] trial;
    int unsigned             b;
    y = x;
    for (int j = 0; j < awvd_pkg::BITS_PER_STAGE; j++) begin
      b     = awvd_pkg::QUOT_W - 1 - k * awvd_pkg::BITS_PER_STAGE - j;
      trial = awvd_pkg::NUM_W'(x.den) << b;
      for (int ch = 0; ch < awvd_pkg::CHANNELS; ch++) begin
        if (y.rem[ch] >= trial) begin
          y.rem[ch]                              = y.rem[ch] - trial;
          y.quot[ch][b[awvd_pkg::QBIT_W-1:0]] = 1'b1;
        end
      end
    end
    return y;
  endfunction

  always_comb begin
    rdy[LAST] = !vld_q[LAST] || m_tready_i;
    for (int k = LAST - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    st_in[0].rem   = acc_i.num;
    st_in[0].quot  = '0;
    st_in[0].den   = acc_i.den;
    st_in[0].zero  = acc_i.zero;
    st_in[0].alpha = acc_i.alpha;
    vld_in[0]      = acc_valid_i;
    for (int k = 1; k < awvd_pkg::DIV_STAGES; k++) begin
      st_in[k]  = st_q[k-1];
      vld_in[k] = vld_q[k-1];
    end
    for (int k = 0; k < awvd_pkg::DIV_STAGES; k++) begin
      st_d[k] = div_step(st_in[k], k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < awvd_pkg::DIV_STAGES; k++) begin
        if (rdy[k]) vld_q[k] <= vld_in[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < awvd_pkg::DIV_STAGES; k++) begin
      if (rdy[k] && vld_in[k]) st_q[k] <= st_d[k];
    end
  end

  always_comb begin
    m_tdata_o = '0;
    for (int ch = 0; ch < awvd_pkg::CHANNELS; ch++) begin
      m_tdata_o[ch*awvd_pkg::BYTE_W +: awvd_pkg::BYTE_W] =
        st_q[LAST].zero ? '0 : st_q[LAST].quot[ch];
    end
    m_tdata_o[awvd_pkg::ALPHA_BYTE*awvd_pkg::BYTE_W +: awvd_pkg::BYTE_W] = st_q[LAST].alpha;
  end

  assign acc_ready_o = rdy[0];
  assign m_tvalid_o  = vld_q[LAST];

endmodule

// ----- sv/alpha_weighted_voxel_downsample.sv -----
// ----------------------------------------------------------------------------
// alpha_weighted_voxel_downsample
// Alpha-weighted 2x2x2 box downsample of RGBA8 voxels to one mip voxel.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one 2x2x2 voxel block per word: eight RGBA8 corners,
//   corner 0 in the lowest 32 bits, red in the low byte of each corner.
//   m_axis returns one RGBA8 voxel per input word, in input order.
//   Path: an accepted word passes two product/sum stages, one queue slot and
//   four divider stages of two quotient bits each before its result can be
//   taken.
//   Throughput: one word per cycle while the receiver does not stall, set by
//   the divider pipeline which finishes one block per cycle.
//   Reset clears every valid flag and the queue pointers; no words are
//   held afterwards and s_axis_tready rises straight away.
//   When the receiver stalls, the divider fills first, then the four-entry
//   queue, then the front stages; s_axis_tready falls only once ten words
//   are in flight. The output word holds steady while stalled.
// ----------------------------------------------------------------------------
module alpha_weighted_voxel_downsample (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // voxel_0 .. voxel_7, 32 bits each
  input  logic [awvd_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // red_out, green_out, blue_out, alpha_out, 8 bits each
  output logic [awvd_pkg::OUT_W-1:0]  m_axis_tdata
);

  awvd_pkg::acc_t front_acc, queue_acc;
  logic front_valid, front_ready, queue_valid, queue_ready;

  awvd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .acc_valid_o (front_valid),
    .acc_ready_i (front_ready),
    .acc_o       (front_acc)
  );

  awvd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_acc),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_data_o   (queue_acc)
  );

  awvd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_valid_i (queue_valid),
    .acc_ready_o (queue_ready),
    .acc_i       (queue_acc),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata)
  );

endmodule

// ----- sv/awvd_checker.sv -----
// ----------------------------------------------------------------------------
// awvd_checker
// Port-level checks on word accounting, latency and output holding.
// ----------------------------------------------------------------------------
module awvd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [awvd_pkg::OUT_W-1:0]  m_axis_tdata
);

  logic [awvd_pkg::CNT_W-1:0] inflight_q;
  logic in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - 1'b1;
    end
  end

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= awvd_pkg::CNT_W'(awvd_pkg::CAPACITY))
    else $error("more words in flight than the pipeline holds");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> inflight_q != '0)
    else $error("result offered with no word in flight");

  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && inflight_q == '0) |=> !m_axis_tvalid)
    else $error("result appeared too early");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result dropped or changed");

endmodule

bind alpha_weighted_voxel_downsample awvd_checker u_awvd_checker (.*);

// ----- dv/alpha_weighted_voxel_downsample_tb.sv -----
// ----------------------------------------------------------------------------
// alpha_weighted_voxel_downsample_tb
// Self-checking bench for the 2x2x2 RGBA8 box downsampler. Streams directed
// and random voxel blocks under random stalls on both sides, predicts each
// coarse voxel and compares every returned word in order.
// ----------------------------------------------------------------------------
module alpha_weighted_voxel_downsample_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GAP_MAX       = 17;
  localparam int unsigned QUIET_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned RANDOM_BLOCKS = 800;
  localparam int unsigned REPORT_MAX    = 10;

  typedef logic [awvd_pkg::IN_W-1:0] block_t;

  typedef struct packed {
    logic [awvd_pkg::BYTE_W-1:0] alpha;
    logic [awvd_pkg::BYTE_W-1:0] blue;
    logic [awvd_pkg::BYTE_W-1:0] green;
    logic [awvd_pkg::BYTE_W-1:0] red;
  } voxel_t;

  typedef enum int unsigned {
    MIX_ANY,
    MIX_SPARSE,
    MIX_FLAT,
    MIX_FAINT,
    MIX_STARK
  } mix_e;

  class mip_ledger;
    voxel_t      voxels_due[$];
    int unsigned faults;

    function voxel_t coarse_voxel(block_t blk);
      logic [awvd_pkg::NUM_W-1:0]  wsum [awvd_pkg::CHANNELS];
      logic [awvd_pkg::ASUM_W-1:0] asum;
      logic [awvd_pkg::BYTE_W-1:0] a;
      logic [awvd_pkg::BYTE_W-1:0] q [awvd_pkg::CHANNELS];
      voxel_t                      v;
      asum = '0;
      for (int j = 0; j < awvd_pkg::CHANNELS; j++) wsum[j] = '0;
      for (int c = 0; c < awvd_pkg::CORNERS; c++) begin
        a    = blk[c*awvd_pkg::VOXEL_W + awvd_pkg::ALPHA_BYTE*awvd_pkg::BYTE_W +:
                   awvd_pkg::BYTE_W];
        asum = asum + awvd_pkg::ASUM_W'(a);
        for (int j = 0; j < awvd_pkg::CHANNELS; j++) begin
          wsum[j] = wsum[j]
                  + awvd_pkg::NUM_W'(blk[c*awvd_pkg::VOXEL_W + j*awvd_pkg::BYTE_W +:
                                         awvd_pkg::BYTE_W])
                  * awvd_pkg::NUM_W'(a);
        end
      end
      for (int j = 0; j < awvd_pkg::CHANNELS; j++) begin
        if (asum == '0) begin
          q[j] = '0;
        end else begin
          q[j] = awvd_pkg::BYTE_W'((wsum[j] + awvd_pkg::NUM_W'(asum >> 1))
                                   / awvd_pkg::NUM_W'(asum));
        end
      end
      v.red   = q[0];
      v.green = q[1];
      v.blue  = q[2];
      v.alpha = awvd_pkg::BYTE_W'((asum + awvd_pkg::ASUM_W'(awvd_pkg::ROUND_ALPHA))
                                  >> awvd_pkg::ALPHA_SHIFT);
      return v;
    endfunction

    function void note_block(block_t blk);
      voxels_due.push_back(coarse_voxel(blk));
    endfunction

    function void check_voxel(voxel_t got);
      voxel_t want;
      if (voxels_due.size() == 0) begin
        faults++;
        if (faults <= REPORT_MAX) $display("unexpected voxel r=%h g=%h b=%h a=%h",
                                           got.red, got.green, got.blue, got.alpha);
        return;
      end
      want = voxels_due.pop_front();
      if (got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.alpha !== want.alpha) begin
        faults++;
        if (faults <= REPORT_MAX) begin
          $display("voxel mismatch: expected r=%h g=%h b=%h a=%h, got r=%h g=%h b=%h a=%h",
                   want.red, want.green, want.blue, want.alpha,
                   got.red, got.green, got.blue, got.alpha);
        end
      end
    endfunction

    function int unsigned pending();
      return voxels_due.size();
    endfunction
  endclass

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // voxel_0 .. voxel_7, 32 bits each
  block_t       s_axis_tdata  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // red_out, green_out, blue_out, alpha_out, 8 bits each
  logic [awvd_pkg::OUT_W-1:0] m_axis_tdata;

  logic tx_calm = 1'b0;
  logic rx_calm = 1'b0;

  mip_ledger ledger = new();

  alpha_weighted_voxel_downsample dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) ledger.note_block(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) ledger.check_voxel(voxel_t'(m_axis_tdata));
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni === 1'b1);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[alpha_weighted_voxel_downsample] ERROR");
    $finish;
  end

  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, GAP_MAX);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_block(block_t blk);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= blk;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // hold the sender until every predicted voxel has returned
  task automatic drain_voxels();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (ledger.pending() != 0);
  endtask

  function automatic block_t make_block(mix_e mix);
    block_t                      blk;
    logic [31:0]                 vx;
    logic [awvd_pkg::BYTE_W-1:0] shared_a;
    shared_a = awvd_pkg::BYTE_W'($urandom);
    for (int c = 0; c < awvd_pkg::CORNERS; c++) begin
      vx = $urandom;
      case (mix)
        MIX_SPARSE: begin
          vx[31:24] = ($urandom_range(0, 3) == 0) ? awvd_pkg::BYTE_W'($urandom) : 8'h00;
        end
        MIX_FLAT: begin
          vx[31:24] = shared_a;
        end
        MIX_FAINT: begin
          vx[31:24] = awvd_pkg::BYTE_W'($urandom_range(0, 3));
        end
        MIX_STARK: begin
          for (int k = 0; k < awvd_pkg::CHANNELS; k++) begin
            vx[k*awvd_pkg::BYTE_W +: awvd_pkg::BYTE_W] = {awvd_pkg::BYTE_W{1'($urandom)}};
          end
        end
        default: begin
        end
      endcase
      blk[c*awvd_pkg::VOXEL_W +: awvd_pkg::VOXEL_W] = vx;
    end
    return blk;
  endfunction

  initial begin
    block_t blk;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_block('0);
    send_block({awvd_pkg::CORNERS{32'hFFFF_FFFF}});
    send_block({awvd_pkg::CORNERS{32'h00FF_FFFF}});
    blk = make_block(MIX_ANY);
    for (int c = 0; c < awvd_pkg::CORNERS; c++) begin
      blk[c*awvd_pkg::VOXEL_W + 24 +: awvd_pkg::BYTE_W] = '0;
    end
    send_block(blk);
    for (int c = 0; c < awvd_pkg::CORNERS; c++) begin
      blk = make_block(MIX_ANY);
      for (int k = 0; k < awvd_pkg::CORNERS; k++) begin
        blk[k*awvd_pkg::VOXEL_W + 24 +: awvd_pkg::BYTE_W] = (k == c) ? 8'hFF : 8'h00;
      end
      send_block(blk);
    end
    // round half up on the weighted mean
    blk = '0;
    blk[0*awvd_pkg::VOXEL_W +: awvd_pkg::VOXEL_W] = 32'h0100_0000;
    blk[1*awvd_pkg::VOXEL_W +: awvd_pkg::VOXEL_W] = 32'h0101_0101;
    send_block(blk);
    // alpha mean just below and at the rounding step
    blk = '0;
    blk[24 +: awvd_pkg::BYTE_W] = 8'd3;
    send_block(blk);
    blk[24 +: awvd_pkg::BYTE_W] = 8'd4;
    send_block(blk);
    send_block({awvd_pkg::CORNERS{32'hAAAA_AAAA}});
    send_block({awvd_pkg::CORNERS{32'h5555_5555}});
    blk = {awvd_pkg::CORNERS{32'hFF00_0000}};
    blk[awvd_pkg::VOXEL_W-1:0] = 32'hFFFF_FFFF;
    send_block(blk);

    for (int i = 0; i < RANDOM_BLOCKS; i++) begin
      if (i % 100 == 0) begin
        tx_calm <= (i >= 200 && i < 300) || ($urandom_range(0, 3) == 0);
        rx_calm <= (i >= 200 && i < 300) || ($urandom_range(0, 3) == 0);
      end
      if (i == RANDOM_BLOCKS / 2) drain_voxels();
      send_block(make_block(mix_e'($urandom_range(0, 4))));
    end

    drain_voxels();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (ledger.faults == 0 && ledger.pending() == 0) begin
      $display("[alpha_weighted_voxel_downsample] OK");
    end else begin
      $display("[alpha_weighted_voxel_downsample] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/awvd_pkg.sv
sv/awvd_front.sv
sv/awvd_queue.sv
sv/awvd_back.sv
sv/alpha_weighted_voxel_downsample.sv
sv/awvd_checker.sv
dv/alpha_weighted_voxel_downsample_tb.sv
